>>> src/tap_pkg.sv
// ----------------------------------------------------------------------------
// tap_pkg
// Shared types and codes for the timed activity protector.
// ----------------------------------------------------------------------------
package tap_pkg;

   // Default width of time stamps and time registers.
   localparam int TimeWidthDefault = 32;

   // Width of the time field and configuration data on the ports.
   localparam int PortTimeWidth = 32;

   // Register index width on the configuration port.
   localparam int CsrIndexWidth = 2;

   // Padded beat widths.
   localparam int ReqDataWidth = 40;
   localparam int RspDataWidth = 8;

   typedef enum logic [1:0] {
      MODE_FIRST = 2'd0,
      MODE_RESET = 2'd1,
      MODE_WORK  = 2'd2,
      MODE_PAUSE = 2'd3
   } mode_type;

   typedef logic [2:0] op_type;

   localparam op_type OP_COMPARE     = 3'd0;
   localparam op_type OP_FORCE_RESET = 3'd1;
   localparam op_type OP_PAUSE       = 3'd2;
   localparam op_type OP_INIT        = 3'd3;
   localparam op_type OP_RELOAD      = 3'd4;

   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam csr_index_type CSR_FIRST_TIME_DEFAULT = 2'd0;
   localparam csr_index_type CSR_REQUEST_MAX_TIME   = 2'd1;
   localparam csr_index_type CSR_RESET_TIME         = 2'd2;

endpackage

>>> src/timed_activity_protector_core.sv
// ----------------------------------------------------------------------------
// timed_activity_protector_core
// Four-mode guard for a timed request: first start, reset lockout, in work
// and pause.
// ----------------------------------------------------------------------------
// Each request beat carries an op (tuser) and a time stamp, request status and
// pause level (tdata). The block answers every request beat with exactly one
// response beat holding the protector output after that step. A beat is
// handled at the edge that accepts it: the op is decoded and the mode and
// time registers are updated, and the output level is loaded into the
// response register at the same edge, so the response shows up in the next
// cycle. A new request beat is accepted every cycle as long as the response
// register is empty or is being drained in that cycle; the rate is one beat
// per clock, set by the single compare/add path from the request to the state
// registers. Configuration registers are written through the csr_ channel,
// which is always ready, and must only be written while the block is idle.
// Times are TIME_WIDTH bits wide (8 to 63); time stamps and register data
// arrive as 32-bit fields and are cut to TIME_WIDTH bits when it is narrower.
module timed_activity_protector_core #(
   parameter int TIME_WIDTH = tap_pkg::TimeWidthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: time_stamp[31:0], request_active[32], pause_output[33], zero pad
   input  logic [tap_pkg::ReqDataWidth-1:0]   req_tdata,
   // tuser: op[2:0]
   input  logic [2:0]                         req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: protect_out[0], zero pad
   output logic [tap_pkg::RspDataWidth-1:0]   rsp_tdata,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tap_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [tap_pkg::PortTimeWidth-1:0]  csr_data
);
   import tap_pkg::*;

   // Bits of a 32-bit port value that survive into a TIME_WIDTH register.
   localparam int LoadWidth = (TIME_WIDTH < PortTimeWidth) ? TIME_WIDTH : PortTimeWidth;
   localparam int SumWidth  = TIME_WIDTH + 1;

   typedef logic [TIME_WIDTH-1:0] time_type;
   typedef logic [SumWidth-1:0]   sum_type;

   localparam time_type TimeMax = {TIME_WIDTH{1'b1}};

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   time_type first_time_default_ff;
   time_type request_max_time_ff;
   time_type reset_time_ff;

   mode_type mode_ff, mode_in;
   logic     out_level_ff, out_level_in;
   logic     held_pause_level_ff, held_pause_level_in;
   time_type window_end_ff, window_end_in;
   time_type lockout_stamp_ff, lockout_stamp_in;
   time_type last_active_stamp_ff, last_active_stamp_in;
   time_type saved_window_end_ff, saved_window_end_in;

   logic     rsp_valid_ff, rsp_valid_in;

   // ------------------------------------------------------------------------
   // Beat unpacking and handshake
   // ------------------------------------------------------------------------
   op_type   req_op;
   time_type req_time;
   logic     req_active;
   logic     req_pause_level;
   logic     req_fire;
   logic     csr_fire;

   assign req_op          = req_tuser;
   assign req_time        = TIME_WIDTH'(req_tdata[LoadWidth-1:0]);
   assign req_active      = req_tdata[PortTimeWidth];
   assign req_pause_level = req_tdata[PortTimeWidth+1];

   // Take a new beat whenever the response slot is free or drains now.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // ------------------------------------------------------------------------
   // Time comparisons (sums one bit wider, never wrap)
   // ------------------------------------------------------------------------
   sum_type  lockout_end;
   sum_type  idle_end;
   sum_type  advanced_window;
   time_type advanced_window_sat;
   logic     lockout_over;
   logic     idle_too_long;
   logic     before_window;

   assign lockout_end     = SumWidth'(lockout_stamp_ff) + SumWidth'(reset_time_ff);
   assign idle_end        = SumWidth'(last_active_stamp_ff) + SumWidth'(request_max_time_ff);
   assign advanced_window = SumWidth'(saved_window_end_ff) + SumWidth'(lockout_stamp_ff);

   // Clamp the advanced window end at the largest time value.
   assign advanced_window_sat = advanced_window[TIME_WIDTH] ? TimeMax
                                                            : advanced_window[TIME_WIDTH-1:0];

   assign lockout_over  = SumWidth'(req_time) > lockout_end;
   assign idle_too_long = SumWidth'(req_time) > idle_end;
   assign before_window = window_end_ff > req_time;

   // ------------------------------------------------------------------------
   // Next mode
   // ------------------------------------------------------------------------
   always_comb begin
      mode_in = mode_ff;
      if (req_fire) begin
         case (req_op)
            OP_COMPARE: begin
               unique case (mode_ff)
                  MODE_FIRST: begin
                     if (req_active) begin
                        mode_in = MODE_WORK;
                     end else if (!before_window) begin
                        mode_in = MODE_RESET;
                     end
                  end
                  MODE_RESET: begin
                     if (lockout_over) begin
                        mode_in = MODE_FIRST;
                     end
                  end
                  MODE_WORK: begin
                     if (!req_active && idle_too_long) begin
                        mode_in = MODE_RESET;
                     end
                  end
                  MODE_PAUSE: begin
                     mode_in = MODE_FIRST;
                  end
                  default: begin
                     mode_in = MODE_FIRST;
                  end
               endcase
            end
            OP_FORCE_RESET: mode_in = MODE_RESET;
            OP_PAUSE:       mode_in = MODE_PAUSE;
            OP_INIT:        mode_in = MODE_FIRST;
            default:        mode_in = mode_ff;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Output level and time registers
   // ------------------------------------------------------------------------
   always_comb begin
      out_level_in         = out_level_ff;
      held_pause_level_in  = held_pause_level_ff;
      window_end_in        = window_end_ff;
      lockout_stamp_in     = lockout_stamp_ff;
      last_active_stamp_in = last_active_stamp_ff;
      saved_window_end_in  = saved_window_end_ff;
      if (req_fire) begin
         case (req_op)
            OP_COMPARE: begin
               unique case (mode_ff)
                  MODE_FIRST: begin
                     if (req_active) begin
                        // Enter work, keep the output as it is.
                     end else if (before_window) begin
                        out_level_in = 1'b1;
                     end else begin
                        // Trip: remember the window so it can be advanced later.
                        saved_window_end_in = window_end_ff;
                        out_level_in        = 1'b0;
                        lockout_stamp_in    = req_time;
                     end
                  end
                  MODE_RESET: begin
                     if (lockout_over) begin
                        window_end_in = advanced_window_sat;
                        out_level_in  = 1'b0;
                     end
                  end
                  MODE_WORK: begin
                     if (req_active) begin
                        last_active_stamp_in = req_time;
                        out_level_in         = 1'b1;
                     end else if (idle_too_long) begin
                        out_level_in     = 1'b0;
                        lockout_stamp_in = req_time;
                     end
                  end
                  MODE_PAUSE: begin
                     out_level_in = held_pause_level_ff;
                  end
                  default: begin
                     out_level_in = held_pause_level_ff;
                  end
               endcase
            end
            OP_FORCE_RESET: begin
               out_level_in     = 1'b0;
               lockout_stamp_in = req_time;
            end
            OP_PAUSE: begin
               held_pause_level_in = req_pause_level;
            end
            OP_INIT: begin
               out_level_in         = 1'b0;
               held_pause_level_in  = 1'b0;
               window_end_in        = first_time_default_ff;
               lockout_stamp_in     = '0;
               last_active_stamp_in = '0;
               saved_window_end_in  = '0;
            end
            OP_RELOAD: begin
               window_end_in = first_time_default_ff;
            end
            default: begin
               // Unused op: hold the state, answer with the current level.
            end
         endcase
      end
   end

   // Hold a response until taken; load a new one with every accepted beat.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff               <= MODE_FIRST;
         out_level_ff          <= 1'b0;
         held_pause_level_ff   <= 1'b0;
         window_end_ff         <= '0;
         lockout_stamp_ff      <= '0;
         last_active_stamp_ff  <= '0;
         saved_window_end_ff   <= '0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         mode_ff               <= mode_in;
         out_level_ff          <= out_level_in;
         held_pause_level_ff   <= held_pause_level_in;
         window_end_ff         <= window_end_in;
         lockout_stamp_ff      <= lockout_stamp_in;
         last_active_stamp_ff  <= last_active_stamp_in;
         saved_window_end_ff   <= saved_window_end_in;
         rsp_valid_ff          <= rsp_valid_in;
      end
   end

   // Configuration registers; an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_time_default_ff <= '0;
         request_max_time_ff   <= '0;
         reset_time_ff         <= '0;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_FIRST_TIME_DEFAULT: first_time_default_ff <= TIME_WIDTH'(csr_data[LoadWidth-1:0]);
            CSR_REQUEST_MAX_TIME:   request_max_time_ff   <= TIME_WIDTH'(csr_data[LoadWidth-1:0]);
            CSR_RESET_TIME:         reset_time_ff         <= TIME_WIDTH'(csr_data[LoadWidth-1:0]);
            default: begin
            end
         endcase
      end
   end

   // The level register only moves with an accepted beat, which also loads
   // the response, so it doubles as the response payload.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-1){1'b0}}, out_level_ff};

`ifndef SYNTH
   a_fire_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted beat produced no response");

   a_lockout_is_disabled: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_RESET |-> !out_level_ff)
      else $error("output enabled during reset lockout");

   a_force_reset_trips: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_op == OP_FORCE_RESET |=> mode_ff == MODE_RESET && !out_level_ff)
      else $error("force reset did not enter lockout");

   a_init_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_op == OP_INIT |=> mode_ff == MODE_FIRST && !out_level_ff
         && window_end_ff == $past(first_time_default_ff))
      else $error("init did not restore first start");
`endif

endmodule

>>> tb/tap_protect_checker.sv
// ----------------------------------------------------------------------------
// tap_protect_checker
// Watches the request, response and register channels of the timed activity
// protector. It predicts protect_out for every accepted request beat and
// compares each response beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tap_protect_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [tap_pkg::ReqDataWidth-1:0]   req_tdata,
   input  logic [2:0]                         req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [tap_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [tap_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [tap_pkg::PortTimeWidth-1:0]  csr_data,
   output int                                 errors,
   output int                                 pending,
   output int                                 checked
);
   import tap_pkg::*;

   localparam int TW = TimeWidthDefault;

   // register copies
   logic [TW-1:0] first_default;
   logic [TW-1:0] idle_limit;
   logic [TW-1:0] lockout_len;

   // protector state copy
   mode_type      mode;
   logic          out_level;
   logic          pause_level;
   logic [TW-1:0] window_end;
   logic [TW-1:0] lockout_stamp;
   logic [TW-1:0] last_active;
   logic [TW-1:0] saved_window;

   logic          protect_out_due[$];
   logic          due;

   initial begin
      errors  = 0;
      pending = 0;
      checked = 0;
   end

   function automatic void clear_protector();
      mode          = MODE_FIRST;
      out_level     = 1'b0;
      pause_level   = 1'b0;
      window_end    = '0;
      lockout_stamp = '0;
      last_active   = '0;
      saved_window  = '0;
   endfunction

   function automatic void trip_protector(logic [TW-1:0] t);
      out_level     = 1'b0;
      lockout_stamp = t;
      mode          = MODE_RESET;
   endfunction

   // Apply one request beat to the state copy and return the output level.
   function automatic logic advance_protector(op_type op, logic [TW-1:0] t,
                                              logic active, logic pout);
      logic [TW:0] sum;
      case (op)
         OP_COMPARE: begin
            case (mode)
               MODE_FIRST: begin
                  if (active) begin
                     mode = MODE_WORK;
                  end else if (window_end > t) begin
                     out_level = 1'b1;
                  end else begin
                     saved_window = window_end;
                     trip_protector(t);
                  end
               end
               MODE_RESET: begin
                  // sums are one bit wider so a late lockout never wraps out
                  if ({1'b0, t} > {1'b0, lockout_stamp} + {1'b0, lockout_len}) begin
                     sum = {1'b0, saved_window} + {1'b0, lockout_stamp};
                     window_end = sum[TW] ? '1 : sum[TW-1:0];
                     mode       = MODE_FIRST;
                     out_level  = 1'b0;
                  end
               end
               MODE_WORK: begin
                  if (active) begin
                     last_active = t;
                     out_level   = 1'b1;
                  end else if ({1'b0, t} > {1'b0, last_active} + {1'b0, idle_limit}) begin
                     trip_protector(t);
                  end
               end
               MODE_PAUSE: begin
                  mode      = MODE_FIRST;
                  out_level = pause_level;
               end
               default: ;
            endcase
         end
         OP_FORCE_RESET: trip_protector(t);
         OP_PAUSE: begin
            mode        = MODE_PAUSE;
            pause_level = pout;
         end
         OP_INIT: begin
            clear_protector();
            window_end = first_default;
         end
         OP_RELOAD: window_end = first_default;
         default: ;
      endcase
      return out_level;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         first_default = '0;
         idle_limit    = '0;
         lockout_len   = '0;
         clear_protector();
         protect_out_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIRST_TIME_DEFAULT: first_default = csr_data[TW-1:0];
               CSR_REQUEST_MAX_TIME:   idle_limit    = csr_data[TW-1:0];
               CSR_RESET_TIME:         lockout_len   = csr_data[TW-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (protect_out_due.size() == 0) begin
               $error("protect_out: response beat with nothing expected, actual %0b",
                      rsp_tdata[0]);
               errors++;
            end else begin
               due = protect_out_due.pop_front();
               checked++;
               if (rsp_tdata[0] !== due) begin
                  $error("protect_out mismatch: expected %0b, actual %0b",
                         due, rsp_tdata[0]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            protect_out_due.push_back(advance_protector(req_tuser, req_tdata[TW-1:0],
                                                        req_tdata[32], req_tdata[33]));
         end
      end
      pending = protect_out_due.size();
   end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the timed activity protector core.
// ----------------------------------------------------------------------------
// A directed sequence walks every op and the boundary cases of each mode;
// then several register settings, from all zero to all ones and a high time
// region that saturates the window end, each drive random request beats.
// Both channels stall in random bursts; the last stretch runs without any.
// A separate checker predicts and compares every response beat.
// ----------------------------------------------------------------------------
module tb_top;
   import tap_pkg::*;

   localparam int            NumPhases     = 8;
   localparam int            ItemsPerPhase = 180;
   localparam int            CalmTail      = 150;
   localparam int            CycleLimit    = 400000;
   localparam csr_index_type CsrUnmapped   = 2'd3;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ReqDataWidth-1:0]        req_tdata  = '0;
   logic [2:0]                     req_tuser  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]        rsp_tdata;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [CsrIndexWidth-1:0]       csr_index  = '0;
   logic [PortTimeWidth-1:0]       csr_data   = '0;

   int   errors;
   int   pending;
   int   checked;
   int   cycle_count = 0;
   int   beats_sent  = 0;
   bit   no_idle     = 1'b0;

   // receiver stall control
   int   stall_left = 0;
   int   stall_pct  = 0;

   always #6 clock = ~clock;

   timed_activity_protector_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tap_protect_checker protect_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .errors     (errors),
      .pending    (pending),
      .checked    (checked)
   );

   // Stall the response side in bursts at a re-picked stall rate, so calm
   // stretches alternate with busy ones.
   always @(posedge clock) begin
      if (cycle_count % 64 == 0) begin
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 5;
            default: stall_pct = 20;
         endcase
      end
      if (no_idle) begin
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(1, 17);
      end
      rsp_tready <= !reset && (stall_left == 0);
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Drive one request beat and hold it until accepted. Return at the
   // accepting edge, so the next beat can follow without a gap.
   task automatic send_beat(op_type op, logic [31:0] t, logic active, logic pout);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(ReqDataWidth - 34){1'b0}}, pout, active, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   // Drive one register write; the caller drops csr_valid after the last one.
   task automatic write_register(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Hold off the sender until every predicted response has come back.
   // Poll at the falling edge, where the checker's queue has settled.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   initial begin
      int            phase;
      int            n;
      int            random_sent;
      int            idle_pct;
      int            active_pct;
      int            step_max;
      int            r;
      logic [31:0]   now;
      logic [31:0]   t;
      logic [31:0]   fdef;
      logic [31:0]   rmax;
      logic [31:0]   rtime;
      op_type        op;

      random_sent = 0;
      idle_pct    = 0;
      active_pct  = 50;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: window 100, idle limit 20, lockout 30.
      write_register(CSR_FIRST_TIME_DEFAULT, 32'd100);
      write_register(CSR_REQUEST_MAX_TIME, 32'd20);
      write_register(CSR_RESET_TIME, 32'd30);
      csr_valid <= 1'b0;

      send_beat(OP_RELOAD, 32'd0, 1'b0, 1'b0);       // load window end
      send_beat(OP_COMPARE, 32'd10, 1'b0, 1'b0);     // inside window: enable
      send_beat(OP_COMPARE, 32'd20, 1'b1, 1'b0);     // active: enter work
      send_beat(OP_COMPARE, 32'd25, 1'b1, 1'b0);     // stamp activity
      send_beat(OP_COMPARE, 32'd45, 1'b0, 1'b0);     // idle exactly at limit: hold
      send_beat(OP_COMPARE, 32'd46, 1'b0, 1'b0);     // idle past limit: trip
      send_beat(OP_COMPARE, 32'd76, 1'b0, 1'b0);     // lockout end not passed
      send_beat(OP_COMPARE, 32'd77, 1'b0, 1'b0);     // leave lockout, advance window
      send_beat(OP_COMPARE, 32'd50, 1'b0, 1'b0);     // window run out: trip
      send_beat(OP_FORCE_RESET, 32'd200, 1'b1, 1'b1);
      send_beat(OP_COMPARE, 32'd231, 1'b0, 1'b0);    // leave lockout
      send_beat(OP_COMPARE, 32'd100, 1'b0, 1'b0);    // inside new window
      send_beat(OP_PAUSE, 32'd0, 1'b0, 1'b0);        // park with output low
      send_beat(OP_COMPARE, 32'd5, 1'b1, 1'b0);
      send_beat(OP_PAUSE, 32'hFFFF_FFFF, 1'b1, 1'b1); // park with output high
      send_beat(OP_COMPARE, 32'd5, 1'b0, 1'b0);
      send_beat(op_type'(3'd5), $urandom, 1'b1, 1'b1); // unused codes: no change
      send_beat(op_type'(3'd6), $urandom, 1'b0, 1'b1);
      send_beat(op_type'(3'd7), $urandom, 1'b1, 1'b0);
      send_beat(OP_INIT, 32'd0, 1'b0, 1'b0);
      send_beat(OP_COMPARE, 32'd100, 1'b0, 1'b0);    // time equals window end: trip
      send_beat(OP_FORCE_RESET, 32'hFFFF_FFF0, 1'b0, 1'b0);
      send_beat(OP_COMPARE, 32'hFFFF_FFFF, 1'b0, 1'b0); // lockout end beyond range
      send_beat(OP_INIT, 32'hFFFF_FFFF, 1'b1, 1'b1);

      // Random part, one register setting per phase.
      for (phase = 0; phase < NumPhases; phase++) begin
         wait_drained();
         now      = $urandom_range(0, 1000);
         step_max = $urandom_range(1, 80);
         case (phase)
            0: begin
               fdef  = '0;
               rmax  = '0;
               rtime = '0;
            end
            1: begin
               fdef  = '1;
               rmax  = '1;
               rtime = '1;
            end
            2: begin
               // high time region: repeated lockouts push the window end to its cap
               fdef  = $urandom_range(500, 5000);
               rmax  = $urandom_range(1, 60);
               rtime = $urandom_range(0, 60);
               now   = 32'hFFFF_F000;
            end
            3: begin
               fdef  = '1;
               rmax  = $urandom_range(0, 50);
               rtime = '0;
            end
            6: begin
               fdef  = $urandom;
               rmax  = $urandom;
               rtime = $urandom;
            end
            default: begin
               fdef  = $urandom_range(0, 2000);
               rmax  = $urandom_range(0, 100);
               rtime = $urandom_range(0, 100);
            end
         endcase
         write_register(CSR_FIRST_TIME_DEFAULT, fdef);
         write_register(CSR_REQUEST_MAX_TIME, rmax);
         write_register(CSR_RESET_TIME, rtime);
         if (phase == 4) begin
            write_register(CsrUnmapped, $urandom);
         end
         csr_valid <= 1'b0;
         send_beat(OP_INIT, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

         for (n = 0; n < ItemsPerPhase; n++) begin
            // re-pick idle rate and request bias now and then
            if (n % 40 == 0) begin
               case ($urandom_range(0, 2))
                  0:       idle_pct = 0;
                  1:       idle_pct = 10;
                  default: idle_pct = 30;
               endcase
            end
            if (n % 20 == 0) begin
               case ($urandom_range(0, 2))
                  0:       active_pct = 10;
                  1:       active_pct = 50;
                  default: active_pct = 90;
               endcase
            end
            if (random_sent >= NumPhases * ItemsPerPhase - CalmTail) begin
               no_idle = 1'b1;
            end
            if (!no_idle && $urandom_range(0, 99) < idle_pct) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 17)) @(posedge clock);
            end

            r = $urandom_range(0, 99);
            if (r < 74) begin
               op = OP_COMPARE;
            end else if (r < 80) begin
               op = OP_FORCE_RESET;
            end else if (r < 87) begin
               op = OP_PAUSE;
            end else if (r < 92) begin
               op = OP_INIT;
            end else if (r < 97) begin
               op = OP_RELOAD;
            end else begin
               op = op_type'($urandom_range(5, 7));
            end

            // advance a running clock mostly; jump anywhere now and then
            if ($urandom_range(0, 99) < 5) begin
               t = $urandom;
            end else begin
               now = now + $urandom_range(0, step_max);
               t   = now;
            end

            send_beat(op, t, ($urandom_range(0, 99) < active_pct),
                      1'($urandom_range(0, 1)));
            random_sent++;
         end
      end

      // Drain and let the pipeline settle before the verdict.
      wait_drained();
      repeat (8) @(posedge clock);

      $display("Run covered %0d request beats over %0d register settings plus a directed walk,",
               beats_sent, NumPhases);
      $display("with %0d response beats checked and %0d mismatches.", checked, errors);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
